// ===== rtl/core/mvrm_pkg.sv =====
// shared types and constants of the resampling mixer
// no dependencies
package mvrm_pkg;

    localparam int VOICES_DEF      = 4;
    localparam int FRAMES_DEF      = 4096;
    localparam int FRAC_DEF        = 16;
    localparam int VOL_MAX         = 100;
    localparam int GAIN_RECIP      = 41944;   // 64/25 scaled by 2^14, rounded up
    localparam int STEP_ONE        = 65536;
    localparam int QUEUE_DEPTH     = 4;
    localparam int IN_DATA_W       = 88;
    localparam int OUT_DATA_W      = 40;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_PLAY   = 3'd1,
        OP_STOP   = 3'd2,
        OP_PAUSE  = 3'd3,
        OP_RESUME = 3'd4,
        OP_ADJUST = 3'd5,
        OP_TICK   = 3'd6
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [1:0]         voice;
        logic [11:0]        fidx;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               loop;
        logic [16:0]        len;
        logic [8:0]         gain;
        logic [18:0]        step;
    } t_cmd;

    // volume*256/100 without a divider: exact for 0..100
    function automatic logic [8:0] gain_of(input logic [6:0] vol);
        logic [22:0] p;
        p = 23'(vol) * 23'(GAIN_RECIP);
        return p[22:14];
    endfunction

endpackage

// ===== rtl/core/mvrm_front.sv =====
// front end: accepts items, drops the ones that do nothing, queues commands
// depends on mvrm_pkg
module mvrm_front #(
    parameter int VOICES           = mvrm_pkg::VOICES_DEF,
    parameter int FRAMES_PER_VOICE = mvrm_pkg::FRAMES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [mvrm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [2:0]                      i_s_tuser,
    output logic                            o_q_valid,
    output mvrm_pkg::t_cmd                  o_q_cmd,
    input  logic                            i_q_pop
);
    import mvrm_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);

    t_cmd             r_buf [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wp, r_rp;
    logic [QPW:0]     r_cnt;
    t_cmd             dec;
    logic             keep, push;
    logic [12:0]      count;
    logic [6:0]       vol;

    always_comb begin
        count     = i_s_tdata[59:47];
        vol       = i_s_tdata[66:60];
        dec.op    = t_op'(i_s_tuser);
        dec.voice = i_s_tdata[1:0];
        dec.fidx  = i_s_tdata[13:2];
        dec.left  = i_s_tdata[29:14];
        dec.right = i_s_tdata[45:30];
        dec.loop  = i_s_tdata[46];
        dec.len   = (32'(count) > FRAMES_PER_VOICE) ? 17'(FRAMES_PER_VOICE) : 17'(count);
        dec.gain  = gain_of((32'(vol) > VOL_MAX) ? 7'(VOL_MAX) : vol);
        dec.step  = i_s_tdata[85:67];
        if (i_s_tuser == 3'(OP_TICK)) begin
            keep = 1'b1;
        end else if (i_s_tuser > 3'(OP_TICK) || 32'(dec.voice) >= VOICES) begin
            keep = 1'b0;
        end else begin
            keep = (dec.op != OP_LOAD) || (32'(dec.fidx) < FRAMES_PER_VOICE);
        end
    end

    assign o_s_tready = (r_cnt != (QPW+1)'(QUEUE_DEPTH));
    assign push       = i_s_tvalid && o_s_tready && keep;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_cmd    = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPW+1)'(push) - (QPW+1)'(i_q_pop);
        end
    end

endmodule

// ===== rtl/core/mvrm_back.sv =====
// back end: voice state, sample store and the per-voice mixing sequencer
// depends on mvrm_pkg
module mvrm_back #(
    parameter int VOICES           = mvrm_pkg::VOICES_DEF,
    parameter int FRAMES_PER_VOICE = mvrm_pkg::FRAMES_DEF,
    parameter int FRAC_BITS        = mvrm_pkg::FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  mvrm_pkg::t_cmd                  i_q_cmd,
    output logic                            o_q_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [mvrm_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import mvrm_pkg::*;

    localparam int KW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LEN_W  = $clog2(FRAMES_PER_VOICE + 1);
    localparam int SI     = (19 - FRAC_BITS > 0) ? 19 - FRAC_BITS : 0;
    localparam int PIW    = ((LEN_W > SI) ? LEN_W : SI) + 1;
    localparam int POS_W  = PIW + FRAC_BITS;
    localparam int DEPTH  = VOICES * FRAMES_PER_VOICE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NUM_W  = FRAC_BITS + 18;
    localparam int ACC_W  = 18 + $clog2(VOICES + 1);
    localparam logic signed [NUM_W-1:0] RND = NUM_W'((1 << FRAC_BITS) - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CHK, S_RD1, S_LERP, S_GAIN, S_ACC, S_OUT
    } t_state;

    t_state                   r_state;
    logic [31:0]              r_mem [DEPTH];
    logic [31:0]              r_rdata, r_w0;
    logic [POS_W-1:0]         r_pos  [VOICES];
    logic [LEN_W-1:0]         r_len  [VOICES];
    logic [18:0]              r_step [VOICES];
    logic [8:0]               r_gain [VOICES];
    logic [VOICES-1:0]        r_play, r_pause, r_loop;
    logic [KW-1:0]            r_k;
    logic signed [NUM_W-1:0]  r_num_l, r_num_r;
    logic signed [25:0]       r_m_l, r_m_r;
    logic signed [ACC_W-1:0]  r_acc_l, r_acc_r;
    logic [3:0]               r_ended;
    logic                     r_ovalid;
    logic [OUT_DATA_W-1:0]    r_odata;

    logic [KW-1:0]            cv;
    logic [PIW-1:0]           ip, ip1, f1, len_x;
    logic                     eligible, ip_ge, last_k;
    logic [ADDR_W-1:0]        base, rd_addr, wr_addr;
    logic [FRAC_BITS-1:0]     t;
    logic signed [16:0]       d_l, d_r;
    logic signed [NUM_W-1:0]  num_l, num_r, sh_l, sh_r;
    logic signed [15:0]       a_l, a_r, li_l, li_r, sat_l, sat_r;
    logic signed [25:0]       m_l, m_r;

    always_comb begin
        cv       = KW'(i_q_cmd.voice);
        ip       = r_pos[r_k][POS_W-1:FRAC_BITS];
        len_x    = PIW'(r_len[r_k]);
        ip_ge    = ip >= len_x;
        ip1      = ip + 1'b1;
        // next frame wraps to the start when looping, otherwise holds
        f1       = (ip1 >= len_x) ? (r_loop[r_k] ? '0 : ip) : ip1;
        eligible = r_play[r_k] && !r_pause[r_k] && (r_len[r_k] != '0);
        last_k   = (r_k == KW'(VOICES - 1));
        base     = ADDR_W'(32'(r_k) * FRAMES_PER_VOICE);
        rd_addr  = base + ADDR_W'((r_state == S_CHK) ? ip : f1);
        wr_addr  = ADDR_W'(32'(cv) * FRAMES_PER_VOICE) + ADDR_W'(i_q_cmd.fidx);
        t        = r_pos[r_k][FRAC_BITS-1:0];
        a_l      = r_w0[15:0];
        a_r      = r_w0[31:16];
        d_l      = 17'($signed(r_rdata[15:0])) - 17'(a_l);
        d_r      = 17'($signed(r_rdata[31:16])) - 17'(a_r);
        num_l    = (NUM_W'(a_l) <<< FRAC_BITS) + d_l * $signed({1'b0, t});
        num_r    = (NUM_W'(a_r) <<< FRAC_BITS) + d_r * $signed({1'b0, t});
        // division by 2^FRAC_BITS, truncated toward zero
        sh_l     = ((r_num_l < 0) ? r_num_l + RND : r_num_l) >>> FRAC_BITS;
        sh_r     = ((r_num_r < 0) ? r_num_r + RND : r_num_r) >>> FRAC_BITS;
        li_l     = sh_l[15:0];
        li_r     = sh_r[15:0];
        m_l      = li_l * $signed({1'b0, r_gain[r_k]});
        m_r      = li_r * $signed({1'b0, r_gain[r_k]});
        sat_l    = (r_acc_l > ACC_W'(32767)) ? 16'sh7fff :
                   (r_acc_l < -ACC_W'(32768)) ? 16'sh8000 : r_acc_l[15:0];
        sat_r    = (r_acc_r > ACC_W'(32767)) ? 16'sh7fff :
                   (r_acc_r < -ACC_W'(32768)) ? 16'sh8000 : r_acc_r[15:0];
    end

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_cmd.op == OP_LOAD) begin
            r_mem[wr_addr] <= {i_q_cmd.right, i_q_cmd.left};
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            r_play   <= '0;
            r_pause  <= '0;
            r_loop   <= '0;
            r_ended  <= '0;
            r_acc_l  <= '0;
            r_acc_r  <= '0;
            for (int v = 0; v < VOICES; v++) begin
                r_pos[v]  <= '0;
                r_len[v]  <= '0;
                r_step[v] <= 19'(STEP_ONE);
                r_gain[v] <= 9'd256;
            end
        end else begin
            if (r_ovalid && i_m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_cmd.op)
                            OP_PLAY: begin
                                r_loop[cv]  <= i_q_cmd.loop;
                                r_len[cv]   <= LEN_W'(i_q_cmd.len);
                                r_pause[cv] <= 1'b0;
                                r_play[cv]  <= 1'b1;
                                r_pos[cv]   <= '0;
                            end
                            OP_STOP: begin
                                if (r_play[cv]) begin
                                    r_play[cv]  <= 1'b0;
                                    r_pause[cv] <= 1'b0;
                                    r_pos[cv]   <= '0;
                                end
                            end
                            OP_PAUSE: begin
                                r_pause[cv] <= 1'b1;
                            end
                            OP_RESUME: begin
                                if (r_play[cv]) begin
                                    r_pause[cv] <= 1'b0;
                                end
                            end
                            OP_ADJUST: begin
                                r_gain[cv] <= i_q_cmd.gain;
                                r_step[cv] <= i_q_cmd.step;
                            end
                            OP_TICK: begin
                                r_k     <= '0;
                                r_acc_l <= '0;
                                r_acc_r <= '0;
                                r_ended <= '0;
                                r_state <= S_CHK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    if (eligible && ip_ge && r_loop[r_k]) begin
                        // one subtraction of the length per cycle
                        r_pos[r_k] <= r_pos[r_k] - (POS_W'(r_len[r_k]) << FRAC_BITS);
                    end else if (eligible && !ip_ge) begin
                        r_state <= S_RD1;
                    end else begin
                        if (eligible) begin
                            r_play[r_k]      <= 1'b0;
                            r_ended[2'(r_k)] <= 1'b1;
                        end
                        r_k     <= last_k ? r_k : r_k + 1'b1;
                        r_state <= last_k ? S_OUT : S_CHK;
                    end
                end
                S_RD1: begin
                    r_w0    <= r_rdata;
                    r_state <= S_LERP;
                end
                S_LERP: begin
                    r_num_l <= num_l;
                    r_num_r <= num_r;
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_m_l   <= m_l;
                    r_m_r   <= m_r;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc_l    <= r_acc_l + ACC_W'($signed(r_m_l[25:8]));
                    r_acc_r    <= r_acc_r + ACC_W'($signed(r_m_r[25:8]));
                    r_pos[r_k] <= r_pos[r_k] + POS_W'(r_step[r_k]);
                    r_k        <= last_k ? r_k : r_k + 1'b1;
                    r_state    <= last_k ? S_OUT : S_CHK;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'b0, r_ended, sat_r, sat_l};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");

    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_k) < VOICES)
        else $error("voice counter out of range");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_IDLE || r_state == S_CHK))
        else $error("command taken while a tick was in progress");

endmodule

// ===== rtl/core/multi_voice_resampling_mixer_top.sv =====
// multi-voice resampling mixer: stereo sample playback with linear interpolation
// depends on mvrm_pkg, mvrm_front, mvrm_back
//
// slave channel carries commands: tuser is the mode (load, play, stop, pause,
// resume, adjust, tick), tdata the operands. only a tick gives a result; the
// master channel then carries one mixed, saturated stereo frame and the mask
// of voices that ran off their end.
// commands pass through a four-entry queue, so the slave side keeps taking
// items while the mixer works or the receiver stalls; tready drops only when
// the queue is full.
// a command other than tick is applied in the back end's idle state. the
// per-voice sequencer and the single read port of the sample store shape ticks:
// an idle voice passes the check state only, a playing one goes through check,
// read, interpolate, gain and accumulate; a looping voice rechecks per wrap.
// the result waits in an output register until taken; the next command is
// then already being processed.
// reset clears all voice state (volume full, step one); the sample store is
// not cleared and must be loaded before a voice plays it.
module multi_voice_resampling_mixer_top #(
    parameter int VOICES           = mvrm_pkg::VOICES_DEF,
    parameter int FRAMES_PER_VOICE = mvrm_pkg::FRAMES_DEF,
    parameter int FRAC_BITS        = mvrm_pkg::FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // voice[1:0] frame_index[13:2] left_sample[29:14] right_sample[45:30]
    // loop_enable[46] frame_count[59:47] volume_percent[66:60] step[85:67]
    input  logic [mvrm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // mode[2:0]
    input  logic [2:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // out_left[15:0] out_right[31:16] ended_mask[35:32]
    output logic [mvrm_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import mvrm_pkg::*;

    logic q_valid, q_pop;
    t_cmd q_cmd;

    mvrm_front #(
        .VOICES           (VOICES),
        .FRAMES_PER_VOICE (FRAMES_PER_VOICE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    mvrm_back #(
        .VOICES           (VOICES),
        .FRAMES_PER_VOICE (FRAMES_PER_VOICE),
        .FRAC_BITS        (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking bench for the multi-voice resampling mixer: directed table, then random
// commands with a built-in mixer predictor and random idling on both stream sides
// depends on mvrm_pkg and multi_voice_resampling_mixer_top
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mvrm_pkg::*;

    localparam logic [2:0] OP_NONE = 3'd7;     // unused mode, ignored by the block
    localparam int FRAMES = 4096;
    localparam int WATCH_LIMIT = 4000;

    typedef struct packed {
        logic [2:0]         op;
        logic [1:0]         voice;
        logic [11:0]        fidx;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               loop;
        logic [12:0]        count;
        logic [6:0]         vol;
        logic [18:0]        step;
    } t_item;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [3:0]         ended;
    } t_mix;

    typedef struct {
        t_item item;
        bit    typed;
        t_mix  mix;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [2:0]            i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    multi_voice_resampling_mixer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // mixer state as the bench sees it
    logic [31:0] store_mem [VOICES_DEF*FRAMES];
    bit          loaded    [VOICES_DEF*FRAMES];
    longint      pos       [VOICES_DEF];
    int          len_q     [VOICES_DEF];
    int          step_q    [VOICES_DEF];
    int          vol_q     [VOICES_DEF];
    bit          playing   [VOICES_DEF];
    bit          paused    [VOICES_DEF];
    bit          looping   [VOICES_DEF];

    t_mix   mix_queue[$];
    t_row   pending_rows[$];       // typed expectations, consumed as items are accepted
    int     errors = 0;
    int     idle_send = 0;
    int     stall_recv = 0;
    int     quiet_cycles = 0;
    bit     running = 1'b0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // 0 idle, 1 runs off its end, 2 plays frames f0/f1 from wrapped integer position ip
    function automatic int voice_frames(input int k, output longint ip, output int f0,
                                        output int f1);
        ip = pos[k] >>> 16;
        f0 = 0;
        f1 = 0;
        if (!playing[k] || paused[k] || len_q[k] == 0) return 0;
        if (ip >= len_q[k]) begin
            if (!looping[k]) return 1;
            ip = ip % len_q[k];
        end
        f0 = int'(ip);
        f1 = f0 + 1;
        if (f1 >= len_q[k]) f1 = looping[k] ? 0 : f0;
        return 2;
    endfunction

    function automatic longint interp(input logic [15:0] a, input logic [15:0] b,
                                      input longint t);
        longint num;
        num = longint'($signed(a)) * (65536 - t) + longint'($signed(b)) * t;
        return num / 65536;
    endfunction

    function automatic logic signed [15:0] clip16(input longint x);
        if (x < -32768) return -16'sd32768;
        if (x > 32767) return 16'sd32767;
        return 16'(x);
    endfunction

    function automatic t_mix mix_tick();
        t_mix   r;
        longint acc_l, acc_r, ip, t, gain;
        int     f0, f1, st;
        logic [31:0] w0, w1;
        acc_l = 0;
        acc_r = 0;
        r.ended = '0;
        for (int k = 0; k < VOICES_DEF; k++) begin
            st = voice_frames(k, ip, f0, f1);
            if (st == 1) begin
                playing[k] = 1'b0;
                r.ended[k] = 1'b1;
            end else if (st == 2) begin
                pos[k] = (ip << 16) | (pos[k] & 64'hFFFF);
                w0 = store_mem[k*FRAMES + f0];
                w1 = store_mem[k*FRAMES + f1];
                t = pos[k] & 64'hFFFF;
                gain = vol_q[k] * 256 / 100;
                acc_l += (interp(w0[15:0], w1[15:0], t) * gain) >>> 8;
                acc_r += (interp(w0[31:16], w1[31:16], t) * gain) >>> 8;
                pos[k] += step_q[k];
            end
        end
        r.left = clip16(acc_l);
        r.right = clip16(acc_r);
        return r;
    endfunction

    // applies one accepted item, returns 1 with the mix when it makes a result
    function automatic bit apply_item(input t_item it, output t_mix r);
        int v;
        v = it.voice;
        r = '0;
        case (it.op)
            OP_TICK: begin
                r = mix_tick();
                return 1'b1;
            end
            OP_LOAD: begin
                store_mem[v*FRAMES + it.fidx] = {it.right, it.left};
                loaded[v*FRAMES + it.fidx] = 1'b1;
            end
            OP_PLAY: begin
                looping[v] = it.loop;
                len_q[v] = (it.count > FRAMES) ? FRAMES : int'(it.count);
                paused[v] = 1'b0;
                playing[v] = 1'b1;
                pos[v] = 0;
            end
            OP_STOP: if (playing[v]) begin
                playing[v] = 1'b0;
                paused[v] = 1'b0;
                pos[v] = 0;
            end
            OP_PAUSE:  paused[v] = 1'b1;
            OP_RESUME: if (playing[v]) paused[v] = 1'b0;
            OP_ADJUST: begin
                vol_q[v] = (it.vol > 100) ? 100 : int'(it.vol);
                step_q[v] = int'(it.step);
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // stream monitor: predict on accepted commands, check accepted mixes
    always @(posedge i_clk) begin
        t_item it;
        t_mix  want, got;
        bit    typed;
        bit    moved;
        t_row  row;
        if (running) begin
            moved = (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready);
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (i_s_tvalid && o_s_tready) begin
                it.op = i_s_tuser;
                {it.step, it.vol, it.count, it.loop, it.right, it.left, it.fidx, it.voice} =
                    i_s_tdata[85:0];
                typed = 1'b0;
                if (pending_rows.size() > 0) begin
                    row = pending_rows.pop_front();
                    typed = row.typed;
                end
                if (apply_item(it, want)) mix_queue.push_back(typed ? row.mix : want);
            end
            if (o_m_tvalid && i_m_tready) begin
                got.left = o_m_tdata[15:0];
                got.right = o_m_tdata[31:16];
                got.ended = o_m_tdata[35:32];
                if (mix_queue.size() == 0) begin
                    $display("mix with none expected at %0t", $realtime);
                    errors++;
                end else begin
                    want = mix_queue.pop_front();
                    if (got.left !== want.left) report("out_left", got.left, want.left);
                    if (got.right !== want.right) report("out_right", got.right, want.right);
                    if (got.ended !== want.ended) report("ended_mask", got.ended, want.ended);
                end
            end
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_recv);
    end

    // starts at a falling edge and returns at the falling edge after acceptance
    task automatic send(input t_item it);
        while ($urandom_range(99) < idle_send) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= it.op;
        i_s_tdata <= {2'b0, it.step, it.vol, it.count, it.loop, it.right, it.left,
                      it.fidx, it.voice};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_row(input t_item it, input bit typed, input t_mix m);
        t_row row;
        row.item = it;
        row.typed = typed;
        row.mix = m;
        pending_rows.push_back(row);
        send(it);
    endtask

    function automatic t_item mk(input logic [2:0] op, input int voice, input int fidx = 0,
                                 input int l = 0, input int r = 0, input int loop = 0,
                                 input int count = 0, input int vol = 0, input int step = 0);
        t_item it;
        it.op = op;
        it.voice = 2'(voice);
        it.fidx = 12'(fidx);
        it.left = 16'(l);
        it.right = 16'(r);
        it.loop = 1'(loop);
        it.count = 13'(count);
        it.vol = 7'(vol);
        it.step = 19'(step);
        return it;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    pick;
        it = '0;
        it.voice = 2'($urandom_range(3));
        it.left = 16'($urandom);
        it.right = 16'($urandom);
        it.loop = 1'($urandom_range(1));
        it.vol = 7'($urandom);
        it.step = 19'($urandom);
        it.fidx = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(15));
        it.count = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(16));
        pick = $urandom_range(99);
        if (pick < 40) it.op = OP_TICK;
        else if (pick < 62) it.op = OP_LOAD;
        else if (pick < 74) it.op = OP_PLAY;
        else if (pick < 86) it.op = OP_ADJUST;
        else if (pick < 90) it.op = OP_STOP;
        else if (pick < 94) it.op = OP_PAUSE;
        else if (pick < 98) it.op = OP_RESUME;
        else it.op = OP_NONE;
        // mostly modest speeds so voices stay in their loaded frames
        if (it.op == OP_ADJUST && $urandom_range(7) != 0) begin
            it.step = 19'($urandom_range(4 * 65536));
        end
        return it;
    endfunction

    // a tick must never touch a frame that was not loaded: load it first
    function automatic bit missing_frame(output t_item ld);
        longint ip;
        int     f0, f1;
        for (int k = 0; k < VOICES_DEF; k++) begin
            if (voice_frames(k, ip, f0, f1) == 2) begin
                if (!loaded[k*FRAMES + f0] || !loaded[k*FRAMES + f1]) begin
                    ld = mk(OP_LOAD, k, loaded[k*FRAMES + f0] ? f1 : f0,
                            $urandom, $urandom);
                    return 1'b1;
                end
            end
        end
        ld = '0;
        return 1'b0;
    endfunction

    initial begin
        t_row   rows[$];
        t_item  it, ld;
        t_mix   none;
        int     phase_idle[4] = '{0, 87, 0, 25};
        int     phase_stall[4] = '{0, 0, 87, 25};
        none = '0;
        for (int k = 0; k < VOICES_DEF; k++) begin
            pos[k] = 0;
            len_q[k] = 0;
            step_q[k] = STEP_ONE;
            vol_q[k] = VOL_MAX;
            playing[k] = 1'b0;
            paused[k] = 1'b0;
            looping[k] = 1'b0;
        end
        rows.push_back('{mk(OP_TICK, 0), 1, none});
        rows.push_back('{mk(OP_LOAD, 0, 0, 32767, -32768), 0, none});
        rows.push_back('{mk(OP_LOAD, 0, 1, -32768, 32767), 0, none});
        rows.push_back('{mk(OP_LOAD, 0, 4095, -1, 1), 0, none});
        rows.push_back('{mk(OP_ADJUST, 0, 0, 0, 0, 0, 0, 127, 19'h7FFFF), 0, none});
        rows.push_back('{mk(OP_PLAY, 0, 0, 0, 0, 1, 2), 0, none});
        // an over-range volume is clipped to full, where the gain product gives back the sample itself
        rows.push_back('{mk(OP_TICK, 0), 1, '{16'sd32767, -16'sd32768, 4'd0}});
        rows.push_back('{mk(OP_TICK, 0), 0, none});
        rows.push_back('{mk(OP_PAUSE, 0), 0, none});
        rows.push_back('{mk(OP_TICK, 0), 1, none});
        rows.push_back('{mk(OP_RESUME, 0), 0, none});
        rows.push_back('{mk(OP_TICK, 0), 0, none});
        rows.push_back('{mk(OP_ADJUST, 0, 0, 0, 0, 0, 0, 100, 65536), 0, none});
        rows.push_back('{mk(OP_PLAY, 0, 0, 0, 0, 0, 1), 0, none});
        rows.push_back('{mk(OP_TICK, 0), 1, '{16'sd32767, -16'sd32768, 4'd0}});
        // non-looping voice runs off its single frame
        rows.push_back('{mk(OP_TICK, 0), 1, '{16'sd0, 16'sd0, 4'd1}});
        rows.push_back('{mk(OP_STOP, 1), 0, none});
        rows.push_back('{mk(OP_PLAY, 1, 0, 0, 0, 1, 0), 0, none});
        rows.push_back('{mk(OP_LOAD, 2, 0, 1000, -1000), 0, none});
        rows.push_back('{mk(OP_LOAD, 2, 1, -1000, 1000), 0, none});
        rows.push_back('{mk(OP_ADJUST, 2, 0, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(OP_PLAY, 2, 0, 0, 0, 1, 8191), 0, none});
        rows.push_back('{mk(OP_TICK, 0), 1, none});
        rows.push_back('{mk(OP_NONE, 3), 0, none});
        rows.push_back('{mk(OP_STOP, 2), 0, none});
        rows.push_back('{mk(OP_STOP, 1), 0, none});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        foreach (rows[i]) send_row(rows[i].item, rows[i].typed, rows[i].mix);

        for (int p = 0; p < 4; p++) begin
            idle_send = phase_idle[p];
            stall_recv = phase_stall[p];
            repeat (260) begin
                it = rand_item();
                if (it.op == OP_TICK) begin
                    while (missing_frame(ld)) send_row(ld, 0, none);
                end
                send_row(it, 0, none);
            end
        end
        i_s_tvalid <= 1'b0;
        stall_recv = 0;
        wait (mix_queue.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
